/* rtl/core/vcme_pkg.sv */
// Package: shared types and constants for the cube moment edge operator.
package vcme_pkg;

  localparam int unsigned CubeDepth = 64;
  localparam int unsigned AddrWidth = 6;

  localparam logic [21:0] ScaleQ24 = 22'd4005269;
  localparam logic [16:0] W080 = 17'd53894;
  localparam logic [16:0] W024 = 17'd15530;
  localparam logic [16:0] W002 = 17'd1015;
  localparam logic [16:0] W100 = 17'd65536;

  typedef struct packed {
    logic       kind;
    logic [3:0] plane_position;
    logic [1:0] frame;
    logic [7:0] pixel;
  } cmd_t;

  typedef struct packed {
    logic        [18:0] zeroth_moment;
    logic signed [19:0] moment_x;
    logic signed [19:0] moment_y;
    logic signed [19:0] moment_t;
    logic signed [15:0] cos_alpha;
    logic signed [15:0] cos_beta;
    logic signed [15:0] cos_gamma;
  } result_t;

  // Weight of one cube cell, chosen by frame and plane position class.
  function automatic logic [16:0] cell_weight(input logic [5:0] addr);
    logic [1:0] cls;
    logic       outer;
    logic [1:0] r;
    logic [1:0] c;
    r = addr[3:2];
    c = addr[1:0];
    outer = (addr[5:4] == 2'd0) || (addr[5:4] == 2'd3);
    if ((r == 2'd1 || r == 2'd2) && (c == 2'd1 || c == 2'd2)) cls = 2'd0;
    else if (r == 2'd1 || r == 2'd2) cls = 2'd1;
    else if (c == 2'd0 || c == 2'd3) cls = 2'd2;
    else cls = 2'd3;
    case (cls)
      2'd0:    cell_weight = outer ? W080 : W100;
      2'd2:    cell_weight = outer ? W002 : W024;
      default: cell_weight = outer ? W024 : W080;
    endcase
  endfunction

endpackage

/* rtl/core/vcme_ram.sv */
// Generic single-port RAM with registered read.
module vcme_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] addr,
  input  logic [Width-1:0]         wdata,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end
endmodule

/* rtl/core/video_cube_moment_edge_operator_top.sv */
// Top level: cube pixel store and sequencer around one shared datapath.
// Load: the pixel is written on the accepted start, busy stays low. Compute: busy
// through 64 pixel reads and a read-pipe drain, scaling, norm, a 29-step square
// root, three restoring divisions and output, and done strobes the result as
// busy drops. A new compute is accepted only once busy is low again.
// Reset clears the store, busy held high.
module video_cube_moment_edge_operator_top (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  vcme_pkg::cmd_t    cmd,
  output logic              done,
  output vcme_pkg::result_t result
);
  localparam int unsigned Depth = vcme_pkg::CubeDepth;
  localparam int unsigned Aw = vcme_pkg::AddrWidth;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_ACC, S_ACC_LAST, S_SCALE, S_NORM, S_SQRT,
    S_DIV, S_OUT
  } state_t;

  state_t state;
  logic [Aw:0] cnt;
  logic [6:0] step;
  logic [1:0] sel;
  logic       ram_we;
  logic [Aw-1:0] ram_addr;
  logic [7:0] ram_wdata, ram_rdata;
  logic [Aw-1:0] rd_addr;
  logic rd_valid;

  logic signed [37:0] s0, sx, sy, st;
  logic        [18:0] m0;
  logic signed [19:0] mv [3];
  logic [40:0] norm;
  logic [57:0] rad;
  logic [30:0] rem;
  logic [28:0] root;
  logic [28:0] sq;
  logic [43:0] dnum;
  logic [30:0] drem;
  logic [24:0] quo;
  logic signed [15:0] cosv [3];

  vcme_ram #(.Width(8), .Depth(Depth)) u_ram (
    .clk(clk), .we(ram_we), .addr(ram_addr), .wdata(ram_wdata), .rdata(ram_rdata)
  );

  always_comb begin
    ram_we = 1'b0;
    ram_addr = cnt[Aw-1:0];
    ram_wdata = 8'd0;
    if (state == S_CLEAR) ram_we = 1'b1;
    else if (state == S_IDLE && start && !cmd.kind) begin
      ram_we = 1'b1;
      ram_addr = {cmd.frame, cmd.plane_position};
      ram_wdata = cmd.pixel;
    end
  end

  // Shared multiply-accumulate: weight times pixel, then times each signed cell coordinate.
  logic [24:0] wp;
  logic signed [27:0] v;
  logic signed [2:0] cx, cy, ct;
  always_comb begin
    wp = 25'(vcme_pkg::cell_weight(rd_addr) * ram_rdata);
    v = signed'({3'b000, wp});
    cx = 3'(signed'({1'b0, rd_addr[1:0], 1'b0}) - 3'sd3);
    cy = 3'(3'sd3 - signed'({1'b0, rd_addr[3:2], 1'b0}));
    ct = 3'(signed'({1'b0, rd_addr[5:4], 1'b0}) - 3'sd3);
  end

  // Scaling: magnitude times K, rounded, saturated.
  // Accumulator magnitudes stay below 2^32.
  logic signed [37:0] sc_in;
  logic [31:0] sc_mag;
  logic [59:0] sc_prod;
  logic [25:0] sc_q;
  always_comb begin
    unique case (sel)
      2'd0: sc_in = sx;
      2'd1: sc_in = sy;
      default: sc_in = st;
    endcase
    sc_mag = sc_in[37] ? 32'(-sc_in) : 32'(sc_in);
    sc_prod = 60'(sc_mag * vcme_pkg::ScaleQ24) + (60'd1 << 33);
    sc_q = 26'(sc_prod >> 34);
  end

  logic [59:0] sc0_prod;
  always_comb sc0_prod = 60'(s0[31:0] * vcme_pkg::ScaleQ24) + (60'd1 << 31);

  logic [19:0] cmag;
  logic [30:0] trial;
  logic [31:0] rtrial;
  always_comb begin
    cmag = mv[sel][19] ? 20'(-mv[sel]) : 20'(mv[sel]);
    trial = {drem[29:0], dnum[43]} - {2'b00, root};
    rtrial = {rem[29:0], rad[57:56]} - {1'b0, root[28:0], 2'b01};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      cnt <= '0;
      done <= 1'b0;
      busy <= 1'b1;
      rd_valid <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_CLEAR: begin
          cnt <= cnt + 1'b1;
          if (cnt == (Aw+1)'(Depth - 1)) begin
            state <= S_IDLE;
            busy <= 1'b0;
          end
        end
        S_IDLE: begin
          cnt <= '0;
          if (start && cmd.kind) begin
            busy <= 1'b1;
            state <= S_ACC;
            s0 <= '0; sx <= '0; sy <= '0; st <= '0;
            rd_valid <= 1'b0;
          end
        end
        S_ACC, S_ACC_LAST: begin
          rd_addr <= cnt[Aw-1:0];
          rd_valid <= (state == S_ACC);
          if (rd_valid) begin
            s0 <= s0 + 38'(v);
            sx <= sx + 38'(v * cx);
            sy <= sy + 38'(v * cy);
            st <= st + 38'(v * ct);
          end
          if (state == S_ACC) begin
            cnt <= cnt + 1'b1;
            if (cnt == (Aw+1)'(Depth - 1)) state <= S_ACC_LAST;
          end else if (!rd_valid) begin
            state <= S_SCALE;
            sel <= 2'd0;
          end
        end
        S_SCALE: begin
          m0 <= (sc0_prod[59:32] > 28'd524287) ? 19'h7FFFF : sc0_prod[50:32];
          if (sc_in[37])
            mv[sel] <= (sc_q > 26'd524288) ? -20'sd524288 : 20'(-signed'({1'b0, sc_q}));
          else
            mv[sel] <= (sc_q > 26'd524287) ? 20'sd524287 : 20'(sc_q);
          if (sel == 2'd2) begin
            state <= S_NORM;
            sel <= 2'd0;
            norm <= '0;
          end else sel <= sel + 1'b1;
        end
        S_NORM: begin
          norm <= norm + 41'(cmag * cmag);
          if (sel == 2'd2) begin
            state <= S_SQRT;
            step <= '0;
            rad <= {1'b0, norm + 41'(cmag * cmag), 16'd0};
            rem <= '0;
            root <= '0;
          end else sel <= sel + 1'b1;
        end
        S_SQRT: begin
          rad <= rad << 2;
          if (!rtrial[31]) begin
            rem <= rtrial[30:0];
            root <= {root[27:0], 1'b1};
          end else begin
            rem <= {rem[28:0], rad[57:56]};
            root <= {root[27:0], 1'b0};
          end
          step <= step + 1'b1;
          if (step == 7'd28) begin
            state <= S_DIV;
            sel <= 2'd0;
            step <= '0;
            sq <= '0;
          end
        end
        S_DIV: begin
          // Compute q = ((mag<<23)+s) / (2s): numerator then shift-subtract.
          if (step == 7'd0) begin
            sq <= root;
            dnum <= 44'({cmag, 23'd0}) + 44'(root);
            drem <= '0;
            quo <= '0;
            root <= {root[27:0], 1'b0};
            step <= 7'd1;
          end else begin
            dnum <= dnum << 1;
            if (!trial[30]) begin
              drem <= trial;
              quo <= {quo[23:0], 1'b1};
            end else begin
              drem <= {drem[29:0], dnum[43]};
              quo <= {quo[23:0], 1'b0};
            end
            step <= step + 1'b1;
            if (step == 7'd44) begin
              root <= sq;
              step <= '0;
              if (sq == '0) cosv[sel] <= '0;
              else begin
                logic [24:0] qf;
                qf = (!trial[30]) ? {quo[23:0], 1'b1} : {quo[23:0], 1'b0};
                if (qf > 25'd16384) qf = 25'd16384;
                cosv[sel] <= mv[sel][19] ? 16'(-signed'({1'b0, qf[14:0]}))
                                         : 16'(qf[14:0]);
              end
              if (sel == 2'd2) state <= S_OUT;
              else sel <= sel + 1'b1;
            end
          end
        end
        S_OUT: begin
          done <= 1'b1;
          busy <= 1'b0;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    result.zeroth_moment = m0;
    result.moment_x = mv[0];
    result.moment_y = mv[1];
    result.moment_t = mv[2];
    result.cos_alpha = cosv[0];
    result.cos_beta = cosv[1];
    result.cos_gamma = cosv[2];
  end
endmodule

/* verif/video_cube_moment_edge_operator_top_tb.sv */
// Testbench for the cube moment edge operator: predicts moments and cosines and checks each result.
`timescale 1ns / 100ps

module video_cube_moment_edge_operator_top_tb;

  localparam int WatchdogLimit = 5000;
  localparam int DrainCycles = 400;
  localparam logic KindLoad = 1'b0;
  localparam logic KindCompute = 1'b1;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic done;
  vcme_pkg::cmd_t cmd = '0;
  vcme_pkg::result_t result;

  video_cube_moment_edge_operator_top dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .cmd(cmd), .done(done), .result(result)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  vcme_pkg::cmd_t    pending_cmds[$];
  vcme_pkg::result_t expected_results[$];
  logic [7:0] cube_model[64];
  int idle_pct = 0;
  int mismatches = 0;
  int transfers = 0;
  int computes = 0;
  int results_seen = 0;
  int quiet_cycles = 0;
  logic hold_sender = 1'b0;

  function automatic longint unsigned root64(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic longint scaled_round(longint acc, int sh);
    longint unsigned mag;
    logic neg;
    neg = acc < 0;
    mag = neg ? longint'(-acc) : acc;
    mag = (mag * 64'd4005269 + (64'd1 << (sh - 1))) >> sh;
    return neg ? -longint'(mag) : longint'(mag);
  endfunction

  function automatic longint clamp(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic logic [15:0] direction_cos(longint m, longint unsigned s);
    longint unsigned mag, q;
    logic neg;
    if (s == 0) return '0;
    neg = m < 0;
    mag = neg ? longint'(-m) : m;
    q = ((mag << 23) + s) / (2 * s);
    if (q > 16384) q = 16384;
    return neg ? 16'(-longint'(q)) : 16'(q);
  endfunction

  function automatic longint weight_of(int f, int p);
    int r, c, cls;
    logic outer;
    r = p >> 2;
    c = p & 3;
    outer = (f == 0) || (f == 3);
    if ((r == 1 || r == 2) && (c == 1 || c == 2)) cls = 0;
    else if (r == 1 || r == 2) cls = 1;
    else if (c == 0 || c == 3) cls = 2;
    else cls = 3;
    case (cls)
      0: return outer ? 53894 : 65536;
      2: return outer ? 1015 : 15530;
      default: return outer ? 15530 : 53894;
    endcase
  endfunction

  function automatic vcme_pkg::result_t cube_moments();
    longint s0, sx, sy, st, v, m0, mx, my, mt;
    longint unsigned n, s;
    vcme_pkg::result_t r;
    s0 = 0; sx = 0; sy = 0; st = 0;
    for (int f = 0; f < 4; f++) begin
      for (int p = 0; p < 16; p++) begin
        v = weight_of(f, p) * cube_model[f * 16 + p];
        s0 += v;
        sx += (2 * (p & 3) - 3) * v;
        sy += (3 - 2 * (p >> 2)) * v;
        st += (2 * f - 3) * v;
      end
    end
    m0 = clamp(scaled_round(s0, 32), 0, 524287);
    mx = clamp(scaled_round(sx, 34), -524288, 524287);
    my = clamp(scaled_round(sy, 34), -524288, 524287);
    mt = clamp(scaled_round(st, 34), -524288, 524287);
    n = mx * mx + my * my + mt * mt;
    s = (n == 0) ? 0 : root64(n << 16);
    r.zeroth_moment = 19'(m0);
    r.moment_x = 20'(mx);
    r.moment_y = 20'(my);
    r.moment_t = 20'(mt);
    r.cos_alpha = direction_cos(mx, s);
    r.cos_beta = direction_cos(my, s);
    r.cos_gamma = direction_cos(mt, s);
    return r;
  endfunction

  // driver: advance the queue on each accepted transfer
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else begin
      logic accepted;
      vcme_pkg::cmd_t next_cmd;
      accepted = start && !busy;
      if (accepted) begin
        if (cmd.kind == KindCompute) begin
          expected_results.push_back(cube_moments());
          computes++;
        end else begin
          cube_model[{cmd.frame, cmd.plane_position}] = cmd.pixel;
        end
        transfers++;
      end
      if (start && !accepted) begin
        // hold the pending transfer
      end else if (pending_cmds.size() > 0 && !hold_sender
                   && $urandom_range(99) >= idle_pct) begin
        next_cmd = pending_cmds.pop_front();
        cmd <= next_cmd;
        start <= 1'b1;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst && done) begin
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", result);
      end else begin
        vcme_pkg::result_t exp_r;
        exp_r = expected_results.pop_front();
        results_seen++;
        if (exp_r !== result) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: m0 %0d/%0d mx %0d/%0d my %0d/%0d mt %0d/%0d ca %0d/%0d cb %0d/%0d cg %0d/%0d",
                     exp_r.zeroth_moment, result.zeroth_moment, exp_r.moment_x,
                     result.moment_x, exp_r.moment_y, result.moment_y, exp_r.moment_t,
                     result.moment_t, exp_r.cos_alpha, result.cos_alpha,
                     exp_r.cos_beta, result.cos_beta, exp_r.cos_gamma, result.cos_gamma);
        end
      end
    end
  end

  // watchdog: count cycles with no transfer and no result
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > WatchdogLimit) begin
      $display("watchdog expired");
      $display("DONE: errors detected");
      $finish;
    end
  end

  function automatic vcme_pkg::cmd_t pixel_load(int f, int p, int v);
    vcme_pkg::cmd_t c;
    c.kind = KindLoad;
    c.frame = 2'(f);
    c.plane_position = 4'(p);
    c.pixel = 8'(v);
    return c;
  endfunction

  function automatic vcme_pkg::cmd_t compute_cmd();
    vcme_pkg::cmd_t c;
    c = vcme_pkg::cmd_t'(15'($urandom));
    c.kind = KindCompute;
    return c;
  endfunction

  task automatic wait_drained();
    while (pending_cmds.size() > 0 || start || busy || expected_results.size() > 0)
      @(posedge clk);
  endtask

  task automatic random_phase(int pct, int count);
    int mode;
    idle_pct = pct;
    for (int i = 0; i < count; i++) begin
      mode = $urandom_range(9);
      if (mode < 6) begin
        // refill a random subset of the cube, then compute
        for (int k = $urandom_range(12); k > 0; k--) begin
          pending_cmds.push_back(pixel_load($urandom_range(3), $urandom_range(15),
                                            $urandom_range(1) ? 255 : $urandom_range(255)));
          i++;
        end
        pending_cmds.push_back(compute_cmd());
      end else if (mode < 8) begin
        pending_cmds.push_back(pixel_load($urandom_range(3), $urandom_range(15),
                                          $urandom_range(255)));
      end else begin
        pending_cmds.push_back(compute_cmd());
      end
    end
    wait_drained();
  endtask

  initial begin
    foreach (cube_model[i]) cube_model[i] = 8'd0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // empty cube: norm zero, all cosines zero
    pending_cmds.push_back(compute_cmd());
    // one pixel in a far corner, then the opposite corner too
    pending_cmds.push_back(pixel_load(3, 15, 255));
    pending_cmds.push_back(compute_cmd());
    pending_cmds.push_back(pixel_load(0, 0, 255));
    pending_cmds.push_back(compute_cmd());
    // tiny moment: small value on one corner cell
    pending_cmds.push_back(pixel_load(0, 0, 0));
    pending_cmds.push_back(pixel_load(3, 15, 1));
    pending_cmds.push_back(compute_cmd());
    for (int p = 0; p < 16; p++) pending_cmds.push_back(pixel_load(p & 3, p, 8'hAA ^ p));
    pending_cmds.push_back(compute_cmd());
    wait_drained();

    // fill whole cube with 255, symmetric: first moments zero
    for (int a = 0; a < 64; a++) pending_cmds.push_back(pixel_load(a >> 4, a & 15, 255));
    pending_cmds.push_back(compute_cmd());
    wait_drained();

    random_phase(0, 160);
    random_phase(48, 160);
    // pause the sender until every expected result is back
    pending_cmds.push_back(compute_cmd());
    pending_cmds.push_back(compute_cmd());
    repeat (3) @(posedge clk);
    hold_sender = 1'b1;
    while (expected_results.size() > 0 || busy) @(posedge clk);
    hold_sender = 1'b0;
    wait_drained();
    random_phase(24, 160);
    random_phase(0, 80);

    repeat (DrainCycles) @(posedge clk);
    $display("covered %0d transfers, %0d computes, %0d results checked",
             transfers, computes, results_seen);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("%0d mismatches, %0d results missing", mismatches, expected_results.size());
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
